@@ rtl/pup_pkg.sv @@
`timescale 1ns / 1ps

package pup_pkg;

  // Bus event codes carried in the func field
  typedef enum logic [2:0] {
    FN_WRITE    = 3'd0,
    FN_READ     = 3'd1,
    FN_PEEK     = 3'd2,
    FN_DMA      = 3'd3,
    FN_VBL_START = 3'd4,
    FN_VBL_END  = 3'd5,
    FN_PAT_RET  = 3'd6,
    FN_HIT      = 3'd7
  } func_t;

  // Register numbers on the processor side
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Forwarded pattern memory requests
  localparam logic [1:0] EXT_NONE  = 2'd0;
  localparam logic [1:0] EXT_READ  = 2'd1;
  localparam logic [1:0] EXT_WRITE = 2'd2;

  // Nametable mirroring modes
  localparam logic [1:0] MIR_HORZ = 2'd0;
  localparam logic [1:0] MIR_VERT = 2'd1;
  localparam logic [1:0] MIR_LOW  = 2'd2;
  localparam logic [1:0] MIR_HIGH = 2'd3;

  // Shared state memory: nametable, then sprite memory, then palette
  localparam int MEM_AW    = 12;
  localparam int MEM_DEPTH = 2336;
  localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Fold a 14-bit video address into the 2 KiB nametable
  function automatic logic [10:0] nt_fold(input logic [13:0] a, input logic [1:0] mode);
    logic [10:0] idx;
    case (mode)
      MIR_HORZ: idx = {a[11], a[9:0]};
      MIR_VERT: idx = a[10:0];
      MIR_LOW:  idx = {1'b0, a[9:0]};
      MIR_HIGH: idx = {1'b1, a[9:0]};
      default:  idx = a[10:0];
    endcase
    return idx;
  endfunction

  // Palette entry, with sprite backdrop entries mapped onto background ones
  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] m;
    m = a[4:0];
    if ((m & 5'h13) == 5'h10) begin
      m = {1'b0, m[3:0]};
    end
    return m;
  endfunction

  function automatic logic [MEM_AW-1:0] nt_mem_addr(input logic [13:0] a,
                                                    input logic [1:0] mode);
    return {1'b0, nt_fold(a, mode)};
  endfunction

  function automatic logic [MEM_AW-1:0] spr_mem_addr(input logic [7:0] idx);
    return {4'h8, idx};
  endfunction

  function automatic logic [MEM_AW-1:0] pal_mem_addr(input logic [13:0] a);
    return {7'b1001000, pal_index(a)};
  endfunction

endpackage

@@ rtl/pup_if.sv @@
`timescale 1ns / 1ps

interface pup_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] reg_select;
  logic [7:0] oam_index;
  logic [7:0] data;

  modport source (output valid, func, reg_select, oam_index, data, input ready);
  modport sink   (input valid, func, reg_select, oam_index, data, output ready);
endinterface

interface pup_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  ext_request;
  logic [12:0] ext_address;
  logic [7:0]  ext_data;
  logic        nmi_request;

  modport source (output valid, read_data, ext_request, ext_address, ext_data,
                  nmi_request, input ready);
  modport sink   (input valid, read_data, ext_request, ext_address, ext_data,
                  nmi_request, output ready);
endinterface

@@ rtl/picture_unit_register_port_unit.sv @@
`timescale 1ns / 1ps

// Register port of a tile video unit, processor side.
// in_bus carries one bus event per item (register write, read, peek, sprite
// DMA byte, vblank start or end, returned pattern byte, sprite hit report).
// out_bus returns exactly one result item per input item, in order.
// cfg_we/cfg_wdata set the nametable mirroring mode; write it while idle.
// For each item the accept cycle issues the one access to the shared state
// memory (nametable, sprite memory, palette), and the busy state uses the
// registered read data, updates the registers and loads the result.
// out_bus.valid rises when the busy state finishes the item; no new item is
// accepted until then.
// A result waiting in the output register does not block the next accept;
// only a second finished result stalls, until out_bus.ready takes the first.
// After reset the block sweeps all 2336 bytes of the state memory to zero
// with in_bus.ready low; configuration writes are taken during the sweep.
// Pattern-space data accesses leave on ext_request/ext_address/ext_data;
// their read bytes come back as a pattern-return item.
module picture_unit_register_port_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  pup_in_if.sink     in_bus,
  pup_out_if.source  out_bus
);
  import pup_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        vblank_r, vblank_nxt;
  logic        hit_r, hit_nxt;
  logic [7:0]  oam_ptr_r, oam_ptr_nxt;
  logic        toggle_r, toggle_nxt;
  logic [7:0]  scroll_x_r, scroll_x_nxt;
  logic [7:0]  scroll_y_r, scroll_y_nxt;
  logic [15:0] vaddr_r, vaddr_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [MEM_AW-1:0] clr_cnt_r;

  func_t      func_r;
  logic [2:0] reg_r;
  logic [7:0] data_r;

  logic        out_valid_r;
  logic [7:0]  out_rd_r, rd_nxt;
  logic [1:0]  out_req_r, req_nxt;
  logic [12:0] out_xaddr_r, xaddr_nxt;
  logic [7:0]  out_xdat_r, xdat_nxt;
  logic        out_nmi_r, nmi_nxt;

  logic              in_fire, finish, clearing;
  logic [13:0]       eff_a;
  logic              in_pat, in_pal;
  logic [15:0]       vaddr_step;
  logic              mem_en, mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;
  func_t             in_func;

  // Data port address decode from the current video address
  assign eff_a      = vaddr_r[13:0];
  assign in_pat     = ~eff_a[13];
  assign in_pal     = (eff_a[13:8] == 6'h3F);
  assign vaddr_step = {2'b00, eff_a} + (ctrl_r[2] ? 16'd32 : 16'd1);

  assign in_func = func_t'(in_bus.func);
  assign in_fire = in_bus.valid & in_bus.ready;
  assign finish  = (state_r == ST_BUSY) & (~out_valid_r | out_bus.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == MEM_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_bus.valid) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_bus.ready = 1'b0;
    clearing     = 1'b0;
    case (state_r)
      ST_CLEAR: clearing     = 1'b1;
      ST_IDLE:  in_bus.ready = 1'b1;
      default: ;
    endcase
  end

  // Memory access issued at accept time (or zero fill during the sweep)
  always_comb begin
    mem_en    = in_fire;
    mem_we    = 1'b0;
    mem_wdata = in_bus.data;
    if (in_func == FN_DMA) begin
      mem_addr = spr_mem_addr(in_bus.oam_index);
    end else if (in_bus.reg_select == REG_OAM_DATA) begin
      mem_addr = spr_mem_addr(oam_ptr_r);
    end else if (in_pal) begin
      mem_addr = pal_mem_addr(eff_a);
    end else begin
      mem_addr = nt_mem_addr(eff_a, mirror_r);
    end
    case (in_func)
      FN_DMA: mem_we = 1'b1;
      FN_WRITE: begin
        if (in_bus.reg_select == REG_OAM_DATA) mem_we = 1'b1;
        if (in_bus.reg_select == REG_DATA && !in_pat) mem_we = 1'b1;
      end
      default: ;
    endcase
    if (clearing) begin
      mem_en    = 1'b1;
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = 8'h00;
    end
  end

  pup_mem u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Finish an item: result and register updates
  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    vblank_nxt   = vblank_r;
    hit_nxt      = hit_r;
    oam_ptr_nxt  = oam_ptr_r;
    toggle_nxt   = toggle_r;
    scroll_x_nxt = scroll_x_r;
    scroll_y_nxt = scroll_y_r;
    vaddr_nxt    = vaddr_r;
    rbuf_nxt     = rbuf_r;
    rd_nxt       = 8'h00;
    req_nxt      = EXT_NONE;
    xaddr_nxt    = 13'h0000;
    xdat_nxt     = 8'h00;
    nmi_nxt      = 1'b0;
    case (func_r)
      FN_WRITE: begin
        case (reg_r)
          REG_CTRL:     ctrl_nxt = data_r;
          REG_MASK:     mask_nxt = data_r;
          REG_OAM_ADDR: oam_ptr_nxt = data_r;
          REG_OAM_DATA: oam_ptr_nxt = oam_ptr_r + 8'd1;
          REG_SCROLL: begin
            toggle_nxt = ~toggle_r;
            if (!toggle_r) scroll_x_nxt = data_r;
            else scroll_y_nxt = data_r;
          end
          REG_ADDR: begin
            toggle_nxt = ~toggle_r;
            if (!toggle_r) vaddr_nxt = {data_r, vaddr_r[7:0]};
            else vaddr_nxt = {vaddr_r[15:8], data_r};
          end
          REG_DATA: begin
            vaddr_nxt = vaddr_step;
            if (in_pat) begin
              req_nxt   = EXT_WRITE;
              xaddr_nxt = eff_a[12:0];
              xdat_nxt  = data_r;
            end
          end
          default: ;
        endcase
      end
      FN_READ: begin
        case (reg_r)
          REG_STATUS: begin
            rd_nxt     = {vblank_r, hit_r, 6'b000000};
            toggle_nxt = 1'b0;
            vblank_nxt = 1'b0;
          end
          REG_OAM_DATA: rd_nxt = mem_rdata;
          REG_DATA: begin
            rd_nxt    = rbuf_r;
            vaddr_nxt = vaddr_step;
            if (in_pat) begin
              req_nxt   = EXT_READ;
              xaddr_nxt = eff_a[12:0];
            end else begin
              rbuf_nxt = mem_rdata;
              if (in_pal) rd_nxt = mem_rdata;
            end
          end
          default: ;
        endcase
      end
      FN_PEEK: begin
        case (reg_r)
          REG_CTRL:     rd_nxt = ctrl_r;
          REG_MASK:     rd_nxt = mask_r;
          REG_STATUS:   rd_nxt = {vblank_r, hit_r, 6'b000000};
          REG_OAM_ADDR: rd_nxt = oam_ptr_r;
          REG_OAM_DATA: rd_nxt = mem_rdata;
          REG_SCROLL:   rd_nxt = toggle_r ? scroll_y_r : scroll_x_r;
          REG_ADDR:     rd_nxt = toggle_r ? vaddr_r[7:0] : vaddr_r[15:8];
          default:      rd_nxt = in_pal ? mem_rdata : rbuf_r;
        endcase
      end
      FN_VBL_START: begin
        vblank_nxt = 1'b1;
        nmi_nxt    = ctrl_r[7];
      end
      FN_VBL_END: begin
        vblank_nxt = 1'b0;
        hit_nxt    = 1'b0;
      end
      FN_PAT_RET: rbuf_nxt = data_r;
      FN_HIT:     hit_nxt = data_r[0];
      default: ;
    endcase
  end

  // Control state and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mirror_r    <= MIR_HORZ;
      ctrl_r      <= 8'h00;
      mask_r      <= 8'h00;
      vblank_r    <= 1'b0;
      hit_r       <= 1'b0;
      oam_ptr_r   <= 8'h00;
      toggle_r    <= 1'b0;
      scroll_x_r  <= 8'h00;
      scroll_y_r  <= 8'h00;
      vaddr_r     <= 16'h0000;
      rbuf_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      if (cfg_we) mirror_r <= cfg_wdata;
      if (finish) begin
        ctrl_r      <= ctrl_nxt;
        mask_r      <= mask_nxt;
        vblank_r    <= vblank_nxt;
        hit_r       <= hit_nxt;
        oam_ptr_r   <= oam_ptr_nxt;
        toggle_r    <= toggle_nxt;
        scroll_x_r  <= scroll_x_nxt;
        scroll_y_r  <= scroll_y_nxt;
        vaddr_r     <= vaddr_nxt;
        rbuf_r      <= rbuf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the accepted item and the finished result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      reg_r  <= in_bus.reg_select;
      data_r <= in_bus.data;
    end
    if (finish) begin
      out_rd_r    <= rd_nxt;
      out_req_r   <= req_nxt;
      out_xaddr_r <= xaddr_nxt;
      out_xdat_r  <= xdat_nxt;
      out_nmi_r   <= nmi_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.read_data   = out_rd_r;
  assign out_bus.ext_request = out_req_r;
  assign out_bus.ext_address = out_xaddr_r;
  assign out_bus.ext_data    = out_xdat_r;
  assign out_bus.nmi_request = out_nmi_r;

endmodule

@@ rtl/pup_mem.sv @@
`timescale 1ns / 1ps

module pup_mem (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [pup_pkg::MEM_AW-1:0] addr,
  input  logic [7:0]              wdata,
  output logic [7:0]              rdata
);
  import pup_pkg::*;

  logic [7:0] mem [0:MEM_DEPTH-1];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

import pup_pkg::*;

// One result item as the block returns it
typedef struct packed {
  logic [7:0]  read_data;
  logic [1:0]  ext_request;
  logic [12:0] ext_address;
  logic [7:0]  ext_data;
  logic        nmi_request;
} port_result_t;

// Shadow copy of the register port: predicts each result and checks it
class port_shadow;
  logic [1:0]   mirror;
  logic [7:0]   ctrl, mask, oam_ptr, scroll_x, scroll_y, rbuf;
  logic         vbl, hit, toggle;
  logic [15:0]  vaddr;
  logic [7:0]   oam [256];
  logic [7:0]   nt [2048];
  logic [7:0]   pal [32];
  port_result_t pending_results [$];
  int           errors;

  function new();
    mirror   = MIR_HORZ;
    ctrl     = 8'h00;
    mask     = 8'h00;
    oam_ptr  = 8'h00;
    scroll_x = 8'h00;
    scroll_y = 8'h00;
    rbuf     = 8'h00;
    vbl      = 1'b0;
    hit      = 1'b0;
    toggle   = 1'b0;
    vaddr    = 16'h0000;
    foreach (oam[i]) oam[i] = 8'h00;
    foreach (nt[i]) nt[i] = 8'h00;
    foreach (pal[i]) pal[i] = 8'h00;
    errors = 0;
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Fold a video address onto the 2 KiB nametable for the current mirroring
  function logic [10:0] fold_nametable(logic [15:0] a);
    case (mirror)
      MIR_HORZ: return {a[11], a[9:0]};
      MIR_VERT: return a[10:0];
      MIR_LOW:  return {1'b0, a[9:0]};
      default:  return {1'b1, a[9:0]};
    endcase
  endfunction

  // Sprite backdrop entries alias the background ones
  function logic [4:0] fold_palette(logic [15:0] a);
    logic [4:0] m;
    m = a[4:0];
    if (m[4] && m[1:0] == 2'b00) m[4] = 1'b0;
    return m;
  endfunction

  // Return the effective data-port address and advance by 1 or 32
  function logic [15:0] advance_vaddr();
    logic [15:0] a;
    a = {2'b00, vaddr[13:0]};
    vaddr = a + (ctrl[2] ? 16'd32 : 16'd1);
    return a;
  endfunction

  function void note_access(func_t f, logic [2:0] r, logic [7:0] oi, logic [7:0] d);
    port_result_t res;
    logic [15:0]  a;
    res = '0;
    case (f)
      FN_WRITE: begin
        case (r)
          REG_CTRL:     ctrl = d;
          REG_MASK:     mask = d;
          REG_OAM_ADDR: oam_ptr = d;
          REG_OAM_DATA: begin
            oam[oam_ptr] = d;
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            toggle = ~toggle;
            if (toggle) scroll_x = d;
            else scroll_y = d;
          end
          REG_ADDR: begin
            toggle = ~toggle;
            if (toggle) vaddr[15:8] = d;
            else vaddr[7:0] = d;
          end
          REG_DATA: begin
            a = advance_vaddr();
            if (a < 16'h2000) begin
              res.ext_request = EXT_WRITE;
              res.ext_address = a[12:0];
              res.ext_data    = d;
            end else if (a < 16'h3F00) begin
              nt[fold_nametable(a)] = d;
            end else begin
              pal[fold_palette(a)] = d;
            end
          end
          default: ;
        endcase
      end
      FN_READ: begin
        case (r)
          REG_STATUS: begin
            res.read_data = {vbl, hit, 6'b000000};
            toggle = 1'b0;
            vbl    = 1'b0;
          end
          REG_OAM_DATA: res.read_data = oam[oam_ptr];
          REG_DATA: begin
            res.read_data = rbuf;
            a = advance_vaddr();
            if (a < 16'h2000) begin
              res.ext_request = EXT_READ;
              res.ext_address = a[12:0];
            end else if (a < 16'h3F00) begin
              rbuf = nt[fold_nametable(a)];
            end else begin
              // palette bytes bypass the buffer
              rbuf = pal[fold_palette(a)];
              res.read_data = rbuf;
            end
          end
          default: ;
        endcase
      end
      FN_PEEK: begin
        case (r)
          REG_CTRL:     res.read_data = ctrl;
          REG_MASK:     res.read_data = mask;
          REG_STATUS:   res.read_data = {vbl, hit, 6'b000000};
          REG_OAM_ADDR: res.read_data = oam_ptr;
          REG_OAM_DATA: res.read_data = oam[oam_ptr];
          REG_SCROLL:   res.read_data = toggle ? scroll_y : scroll_x;
          REG_ADDR:     res.read_data = toggle ? vaddr[7:0] : vaddr[15:8];
          default: begin
            a = {2'b00, vaddr[13:0]};
            res.read_data = (a < 16'h3F00) ? rbuf : pal[fold_palette(a)];
          end
        endcase
      end
      FN_DMA:       oam[oi] = d;
      FN_VBL_START: begin
        vbl = 1'b1;
        res.nmi_request = ctrl[7];
      end
      FN_VBL_END: begin
        vbl = 1'b0;
        hit = 1'b0;
      end
      FN_PAT_RET: rbuf = d;
      default:    hit = d[0];
    endcase
    pending_results.push_back(res);
  endfunction

  task check_result(logic [7:0] rd, logic [1:0] req, logic [12:0] xa, logic [7:0] xd,
                    logic nmi);
    port_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result rd=%02h req=%0d addr=%04h with nothing expected", rd, req, xa));
      return;
    end
    want = pending_results.pop_front();
    if (rd !== want.read_data)
      report($sformatf("read_data %02h, expected %02h", rd, want.read_data));
    if (req !== want.ext_request)
      report($sformatf("ext_request %0d, expected %0d", req, want.ext_request));
    if (xa !== want.ext_address)
      report($sformatf("ext_address %04h, expected %04h", xa, want.ext_address));
    if (xd !== want.ext_data)
      report($sformatf("ext_data %02h, expected %02h", xd, want.ext_data));
    if (nmi !== want.nmi_request)
      report($sformatf("nmi_request %0b, expected %0b", nmi, want.nmi_request));
  endtask
endclass

module testbench;
  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  pup_in_if  in_bus ();
  pup_out_if out_bus ();

  picture_unit_register_port_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  port_shadow shadow;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         items_sent = 0;
  bit         pressure_req = 1'b0;
  bit         pressure_done = 1'b0;

  logic [1:0] mirror_plan [8] = '{MIR_HORZ, MIR_VERT, MIR_LOW, MIR_HIGH,
                                  MIR_HIGH, MIR_LOW, MIR_VERT, MIR_HORZ};

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note accepted items and check returned results at each edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_bus.valid && in_bus.ready)
        shadow.note_access(func_t'(in_bus.func), in_bus.reg_select, in_bus.oam_index,
                           in_bus.data);
      if (out_bus.valid === 1'b1 && out_bus.ready)
        shadow.check_result(out_bus.read_data, out_bus.ext_request, out_bus.ext_address,
                            out_bus.ext_data, out_bus.nmi_request);
    end
  end

  // Drive out_bus.ready: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        hold_left = 400;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  // Offer one item and hold it until accepted; valid stays high for the next item
  task automatic put_item(input func_t f, input logic [2:0] r, input logic [7:0] oi,
                          input logic [7:0] d);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= f;
    in_bus.reg_select <= r;
    in_bus.oam_index  <= oi;
    in_bus.data       <= d;
    do @(posedge clk); while (!in_bus.ready);
    if (!((f == FN_WRITE && r == REG_STATUS) ||
          (f == FN_READ && !(r inside {REG_STATUS, REG_OAM_DATA, REG_DATA}))))
      items_sent++;
  endtask

  task automatic wr(input logic [2:0] r, input logic [7:0] d);
    put_item(FN_WRITE, r, rand_byte(), d);
  endtask

  task automatic rd(input logic [2:0] r);
    put_item(FN_READ, r, rand_byte(), rand_byte());
  endtask

  task automatic pk(input logic [2:0] r);
    put_item(FN_PEEK, r, rand_byte(), rand_byte());
  endtask

  task automatic ev(input func_t f, input logic [7:0] d);
    put_item(f, 3'($urandom_range(7)), rand_byte(), d);
  endtask

  task automatic write_mirror(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow.mirror = m;
  endtask

  // Wait for every expected result, then let the pipeline settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (shadow.pending_results.size() != 0 && guard < 50000);
    repeat (6) @(posedge clk);
  endtask

  task automatic directed_items();
    wr(REG_CTRL, 8'h80);
    ev(FN_VBL_START, 8'h00);
    ev(FN_HIT, 8'hFF);
    rd(REG_STATUS);
    wr(REG_STATUS, 8'hFF);
    rd(REG_CTRL);
    // sprite backdrop mirror, then palette read bypassing the buffer
    wr(REG_ADDR, 8'h3F);
    wr(REG_ADDR, 8'h10);
    wr(REG_DATA, 8'hAB);
    wr(REG_ADDR, 8'h3F);
    wr(REG_ADDR, 8'h00);
    rd(REG_DATA);
    // nametable write, then buffered read back
    wr(REG_ADDR, 8'h27);
    wr(REG_ADDR, 8'hFF);
    wr(REG_DATA, 8'h55);
    wr(REG_ADDR, 8'h27);
    wr(REG_ADDR, 8'hFF);
    rd(REG_DATA);
    rd(REG_DATA);
    // unmasked high byte, stride 32, wrap into pattern space
    wr(REG_ADDR, 8'hFF);
    wr(REG_ADDR, 8'hFF);
    pk(REG_ADDR);
    wr(REG_CTRL, 8'h04);
    rd(REG_DATA);
    wr(REG_DATA, 8'hC3);
    rd(REG_DATA);
    ev(FN_PAT_RET, 8'h77);
    wr(REG_SCROLL, 8'h01);
    pk(REG_SCROLL);
    wr(REG_OAM_ADDR, 8'hFF);
    wr(REG_OAM_DATA, 8'h5A);
    pk(REG_OAM_ADDR);
    put_item(FN_DMA, REG_CTRL, 8'hFF, 8'h00);
    ev(FN_VBL_END, 8'h00);
  endtask

  // Pick a high address byte, weighted toward each address region
  function automatic logic [7:0] pick_addr_hi();
    case ($urandom_range(9))
      0, 1, 2: return 8'($urandom_range(8'h1F));
      3, 4:    return 8'h20 + 8'($urandom_range(7)) * 8'd4;
      5, 6:    return 8'($urandom_range(8'h3E, 8'h20));
      7, 8:    return 8'h3F;
      default: return rand_byte();
    endcase
  endfunction

  task automatic aim_vaddr(input logic [7:0] hi, input logic [7:0] lo);
    // mostly clear the toggle first; sometimes leave it as it is
    if ($urandom_range(4) != 0) rd(REG_STATUS);
    wr(REG_ADDR, hi);
    wr(REG_ADDR, lo);
  endtask

  task automatic random_burst();
    logic [7:0] hi, lo;
    int         n;
    hi = pick_addr_hi();
    lo = $urandom_range(1) ? rand_byte() : 8'($urandom_range(15));
    n  = $urandom_range(6, 1);
    case ($urandom_range(11))
      0, 1, 2: begin
        // mixed data-port traffic
        aim_vaddr(hi, lo);
        repeat (n) begin
          case ($urandom_range(4))
            0, 1: wr(REG_DATA, rand_byte());
            2:    rd(REG_DATA);
            3:    pk(REG_DATA);
            default: ev(FN_PAT_RET, rand_byte());
          endcase
        end
      end
      3, 4: begin
        // write a run, then read it back through the buffer
        aim_vaddr(hi, lo);
        repeat (n) wr(REG_DATA, rand_byte());
        aim_vaddr(hi, lo);
        repeat (n + 1) rd(REG_DATA);
      end
      5: begin
        // pattern read answered by a returned byte
        aim_vaddr(8'($urandom_range(8'h1F)), lo);
        rd(REG_DATA);
        ev(FN_PAT_RET, rand_byte());
        rd(REG_DATA);
        pk(REG_DATA);
      end
      6: begin
        wr(REG_CTRL, rand_byte());
        ev(FN_VBL_START, rand_byte());
        pk(REG_STATUS);
        ev(FN_HIT, rand_byte());
        if ($urandom_range(1)) rd(REG_STATUS);
        else ev(FN_VBL_END, rand_byte());
        pk(REG_CTRL);
      end
      7: begin
        wr(REG_OAM_ADDR, rand_byte());
        repeat (n) begin
          case ($urandom_range(3))
            0, 1: wr(REG_OAM_DATA, rand_byte());
            2:    rd(REG_OAM_DATA);
            default: pk(REG_OAM_DATA);
          endcase
        end
        pk(REG_OAM_ADDR);
      end
      8: begin
        repeat (n) put_item(FN_DMA, 3'($urandom_range(7)), rand_byte(), rand_byte());
        rd(REG_OAM_DATA);
      end
      9: begin
        wr(REG_SCROLL, rand_byte());
        pk(REG_SCROLL);
        wr(REG_SCROLL, rand_byte());
        pk(REG_SCROLL);
        pk(REG_ADDR);
        wr(REG_MASK, rand_byte());
        pk(REG_MASK);
      end
      default: begin
        repeat (n) put_item(func_t'($urandom_range(7)), 3'($urandom_range(7)), rand_byte(),
                            rand_byte());
      end
    endcase
  endtask

  initial begin : main
    int target;
    shadow = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 2'b00;
    in_bus.valid      <= 1'b0;
    in_bus.func       <= FN_WRITE;
    in_bus.reg_select <= REG_CTRL;
    in_bus.oam_index  <= 8'h00;
    in_bus.data       <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      write_mirror(mirror_plan[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      if (p == 0) begin
        directed_items();
        // long receiver hold-off while the sender keeps offering
        pressure_req = 1'b1;
      end
      target = items_sent + 160;
      while (items_sent < target) random_burst();
      in_bus.valid <= 1'b0;
      wait_drained();
    end

    if (shadow.pending_results.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.pending_results.size()));
    if (shadow.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/pup_pkg.sv
rtl/pup_if.sv
rtl/pup_mem.sv
rtl/picture_unit_register_port_unit.sv
test/testbench.sv
